// ===== rtl/set_assoc_cache_replacement_defines.svh =====
// Assertion macros shared by the cache replacement RTL.
`ifndef SET_ASSOC_CACHE_REPLACEMENT_DEFINES_SVH
`define SET_ASSOC_CACHE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SACR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SACR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sacr_pkg.sv =====
// Shared constants, types and helpers of the cache replacement block.
`default_nettype none
package sacr_pkg;

    // Geometry of the cache.
    localparam int SETS           = 64;
    localparam int WAYS           = 8;
    localparam int LINE_BYTES     = 64;
    localparam int ADDR_BITS      = 48;
    localparam int USE_COUNT_BITS = 16;

    localparam int OFF_BITS  = $clog2(LINE_BYTES);
    localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TAG_WIDTH = ADDR_BITS - OFF_BITS - ((SETS > 1) ? $clog2(SETS) : 0);
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_OUT_BITS = 3;
    localparam int CNT_BITS  = 32;

    // Line state codes.
    localparam logic [1:0] ST_INVALID   = 2'd0;
    localparam logic [1:0] ST_EXCLUSIVE = 2'd1;
    localparam logic [1:0] ST_MODIFIED  = 2'd2;

    // Replacement policy codes.
    localparam logic [1:0] POL_LRU = 2'd0;
    localparam logic [1:0] POL_MRU = 2'd1;
    localparam logic [1:0] POL_LFU = 2'd2;

    // Access kind.
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } fsm_t;

    typedef logic [WAYS-1:0][TAG_WIDTH-1:0] tag_row_t;

    // Policy and state bookkeeping for all ways of one set.
    typedef struct packed {
        logic [WAYS-1:0][1:0]                states;
        logic [WAYS-1:0][WAY_BITS-1:0]       ranks;
        logic [WAYS-1:0][USE_COUNT_BITS-1:0] counts;
        logic [WAY_BITS-1:0]                 last;
    } meta_row_t;

    // Contents of a set that has never been written.
    function automatic meta_row_t meta_reset_row();
        meta_row_t r;
        r = '0;
        for (int w = 0; w < WAYS; w++) begin
            r.ranks[w] = WAY_BITS'(w);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sacr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/set_assoc_cache_replacement.sv =====
// Top level of the set-associative cache tag model with selectable replacement.
//
// Usage: one access (s_action, s_address) enters on the s_ channel as a valid/ready
// transaction; one result (hit, writeback, way and four running totals) leaves on
// the m_ channel. The policy register is written through cfg_we/cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce. The set's
// tag row and bookkeeping row are read from two RAMs when the transaction is
// accepted. One shared compare unit then visits the ways one per cycle, checking
// tag and state, the rank-zero way and the lowest use count. The update state then
// chooses the way, writes both rows back and loads the result register. A new
// transaction is accepted only after the update state, and s_ready is high only
// while no access is in progress. If the receiver stalls, the result waits in its
// register and a further access can be accepted and scanned; its write-back waits
// until the register is free.
// Reset is synchronous, active low, and takes effect at once: per-set valid flags
// make every set read as all-invalid with ranks equal to way numbers and zero counts,
// so no clearing pass is needed. Totals and the policy register return to zero.
`default_nettype none
`include "set_assoc_cache_replacement_defines.svh"
module set_assoc_cache_replacement (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [1:0]                           cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_action,
    input  wire logic [sacr_pkg::ADDR_BITS-1:0]       s_address,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_hit,
    output logic                                      m_writeback,
    output logic [sacr_pkg::WAY_OUT_BITS-1:0]         m_way,
    output logic [sacr_pkg::CNT_BITS-1:0]             m_access_count,
    output logic [sacr_pkg::CNT_BITS-1:0]             m_hit_count,
    output logic [sacr_pkg::CNT_BITS-1:0]             m_miss_count,
    output logic [sacr_pkg::CNT_BITS-1:0]             m_writeback_count
);

    sacr_pkg::fsm_t state_reg, state_next;

    logic [1:0]                        policy_reg;
    logic                              write_reg;
    logic [sacr_pkg::SET_BITS-1:0]     set_reg;
    logic [sacr_pkg::TAG_WIDTH-1:0]    tag_reg;
    logic [sacr_pkg::SETS-1:0]         row_valid_reg;
    logic                              row_valid_q_reg;
    logic [sacr_pkg::WAY_BITS-1:0]     scan_idx_reg;

    // Scan results.
    logic                              hit_reg, inv_found_reg, lru_found_reg;
    logic [sacr_pkg::WAY_BITS-1:0]     hit_way_reg, inv_way_reg, lru_way_reg, lfu_way_reg;
    logic [sacr_pkg::USE_COUNT_BITS-1:0] lfu_min_reg;

    // Result register and totals.
    logic                              m_valid_reg, m_valid_next;
    logic                              m_hit_reg, m_wb_reg;
    logic [sacr_pkg::WAY_BITS-1:0]     m_way_reg;
    logic [sacr_pkg::CNT_BITS-1:0]     acc_cnt_reg, hit_cnt_reg, miss_cnt_reg, wb_cnt_reg;

    logic                              in_accept;
    logic                              out_free;
    logic                              wr_en;
    logic [sacr_pkg::SET_BITS-1:0]     in_set;
    logic [sacr_pkg::SET_BITS-1:0]     raddr;
    sacr_pkg::tag_row_t                tag_rd, tag_wr;
    logic [$bits(sacr_pkg::meta_row_t)-1:0] meta_rd_bits;
    sacr_pkg::meta_row_t               meta_cur, meta_wr;

    logic [1:0]                        cur_state;
    logic [sacr_pkg::USE_COUNT_BITS-1:0] cur_count;
    logic                              cur_valid;

    logic [sacr_pkg::WAY_BITS-1:0]     victim, acc_way, old_rank;
    logic                              wb;
    logic [sacr_pkg::USE_COUNT_BITS-1:0] base_count;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign wr_en     = (state_reg == sacr_pkg::S_UPDATE) && out_free;
    assign in_set    = s_address[sacr_pkg::OFF_BITS +: sacr_pkg::SET_BITS];
    assign raddr     = (state_reg == sacr_pkg::S_IDLE) ? in_set : set_reg;

    // Row stores: one tag row and one bookkeeping row per set.
    sacr_ram #(
        .WIDTH ($bits(sacr_pkg::tag_row_t)),
        .DEPTH (sacr_pkg::SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (set_reg),
        .wdata (tag_wr),
        .raddr (raddr),
        .rdata (tag_rd)
    );

    sacr_ram #(
        .WIDTH ($bits(sacr_pkg::meta_row_t)),
        .DEPTH (sacr_pkg::SETS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (set_reg),
        .wdata (meta_wr),
        .raddr (raddr),
        .rdata (meta_rd_bits)
    );

    // A set never written reads as its reset contents.
    assign meta_cur = row_valid_q_reg ? sacr_pkg::meta_row_t'(meta_rd_bits)
                                      : sacr_pkg::meta_reset_row();

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sacr_pkg::S_IDLE: begin
                if (s_valid) state_next = sacr_pkg::S_SCAN;
            end
            sacr_pkg::S_SCAN: begin
                if (scan_idx_reg == sacr_pkg::WAY_BITS'(sacr_pkg::WAYS - 1)) begin
                    state_next = sacr_pkg::S_UPDATE;
                end
            end
            sacr_pkg::S_UPDATE: begin
                if (out_free) state_next = sacr_pkg::S_IDLE;
            end
            default: state_next = sacr_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        unique case (state_reg)
            sacr_pkg::S_IDLE: s_ready = 1'b1;
            default:          s_ready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sacr_pkg::S_IDLE;
            policy_reg    <= sacr_pkg::POL_LRU;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
            acc_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            wb_cnt_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) policy_reg <= cfg_wdata;
            if (wr_en) begin
                row_valid_reg[set_reg] <= 1'b1;
                acc_cnt_reg  <= acc_cnt_reg + 1'b1;
                hit_cnt_reg  <= hit_cnt_reg + sacr_pkg::CNT_BITS'(hit_reg);
                miss_cnt_reg <= miss_cnt_reg + sacr_pkg::CNT_BITS'(!hit_reg);
                wb_cnt_reg   <= wb_cnt_reg + sacr_pkg::CNT_BITS'(wb);
            end
        end
    end

    assign m_valid_next = wr_en ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Current way seen by the shared compare unit.
    assign cur_state = meta_cur.states[scan_idx_reg];
    assign cur_count = meta_cur.counts[scan_idx_reg];
    assign cur_valid = (cur_state != sacr_pkg::ST_INVALID);

    // Capture of the access and the way-by-way scan.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            write_reg       <= (s_action == sacr_pkg::ACT_WRITE);
            set_reg         <= in_set;
            tag_reg         <= s_address[sacr_pkg::ADDR_BITS-1 -: sacr_pkg::TAG_WIDTH];
            row_valid_q_reg <= row_valid_reg[in_set];
            scan_idx_reg    <= '0;
            hit_reg         <= 1'b0;
            inv_found_reg   <= 1'b0;
            lru_found_reg   <= 1'b0;
            hit_way_reg     <= '0;
            inv_way_reg     <= '0;
            lru_way_reg     <= '0;
            lfu_way_reg     <= '0;
            lfu_min_reg     <= '0;
        end else if (state_reg == sacr_pkg::S_SCAN) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (!hit_reg && cur_valid && tag_rd[scan_idx_reg] == tag_reg) begin
                hit_reg     <= 1'b1;
                hit_way_reg <= scan_idx_reg;
            end
            if (!inv_found_reg && !cur_valid) begin
                inv_found_reg <= 1'b1;
                inv_way_reg   <= scan_idx_reg;
            end
            if (!lru_found_reg && meta_cur.ranks[scan_idx_reg] == '0) begin
                lru_found_reg <= 1'b1;
                lru_way_reg   <= scan_idx_reg;
            end
            if (scan_idx_reg == '0 || cur_count < lfu_min_reg) begin
                lfu_min_reg <= cur_count;
                lfu_way_reg <= scan_idx_reg;
            end
        end
    end

    // Victim choice by the selected policy.
    always_comb begin
        case (policy_reg)
            sacr_pkg::POL_MRU: begin
                victim = (32'(meta_cur.last) < sacr_pkg::WAYS) ? meta_cur.last : '0;
            end
            sacr_pkg::POL_LFU: victim = lfu_way_reg;
            default:           victim = lru_found_reg ? lru_way_reg : '0;
        endcase
    end

    // Way choice and the new contents of the set.
    always_comb begin
        acc_way  = hit_reg ? hit_way_reg : (inv_found_reg ? inv_way_reg : victim);
        wb       = !hit_reg && !inv_found_reg
                   && (meta_cur.states[acc_way] == sacr_pkg::ST_MODIFIED);
        old_rank = meta_cur.ranks[acc_way];
        tag_wr   = tag_rd;
        meta_wr  = meta_cur;
        if (!hit_reg) tag_wr[acc_way] = tag_reg;
        if (write_reg) begin
            meta_wr.states[acc_way] = sacr_pkg::ST_MODIFIED;
        end else if (!hit_reg) begin
            meta_wr.states[acc_way] = sacr_pkg::ST_EXCLUSIVE;
        end
        base_count = hit_reg ? meta_cur.counts[acc_way] : '0;
        meta_wr.counts[acc_way] = (base_count == '1) ? base_count : base_count + 1'b1;
        for (int w = 0; w < sacr_pkg::WAYS; w++) begin
            if (sacr_pkg::WAY_BITS'(w) == acc_way) begin
                meta_wr.ranks[w] = sacr_pkg::WAY_BITS'(sacr_pkg::WAYS - 1);
            end else if (meta_cur.ranks[w] > old_rank) begin
                meta_wr.ranks[w] = meta_cur.ranks[w] - 1'b1;
            end
        end
        meta_wr.last = acc_way;
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            m_hit_reg <= hit_reg;
            m_wb_reg  <= wb;
            m_way_reg <= acc_way;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_writeback       = m_wb_reg;
    assign m_way             = sacr_pkg::WAY_OUT_BITS'(m_way_reg);
    assign m_access_count    = acc_cnt_reg;
    assign m_hit_count       = hit_cnt_reg;
    assign m_miss_count      = miss_cnt_reg;
    assign m_writeback_count = wb_cnt_reg;

    // Checks on the sequencer and the totals.
    `SACR_ASSERT_NOW(a_totals_agree, aclk, aresetn, 1'b1, hit_cnt_reg + miss_cnt_reg == acc_cnt_reg, "hit and miss totals do not add up to the access total")
    `SACR_ASSERT_NOW(a_no_hit_writeback, aclk, aresetn, m_valid, !(m_hit && m_writeback), "write-back reported on a hit")
    `SACR_ASSERT_NEXT(a_scan_starts, aclk, aresetn, in_accept, state_reg == sacr_pkg::S_SCAN && scan_idx_reg == '0, "scan did not start at way zero")
    `SACR_ASSERT_NEXT(a_one_count, aclk, aresetn, wr_en, acc_cnt_reg == $past(acc_cnt_reg) + 1'b1, "access total did not advance by one")

endmodule
`default_nettype wire
